/* hdl/manchester_table_decoder_defines.svh */
// ----------------------------------------------------------------------------
// Manchester table decoder assertion macros
// Shared concurrent assertion forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef MANCHESTER_TABLE_DECODER_DEFINES_SVH
`define MANCHESTER_TABLE_DECODER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MTD_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("manchester_table_decoder: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define MTD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("manchester_table_decoder: next-cycle check failed");

`endif

/* hdl/mtd_pkg.sv */
// ----------------------------------------------------------------------------
// Manchester table decoder package
// State and action codes and the result record shared by the modules and interfaces.
// ----------------------------------------------------------------------------
package mtd_pkg;

  // Decoder states: last half-bit pair seen and what the machine expects.
  typedef enum logic [3:0] {
    ST_00_START0 = 4'd0,
    ST_01_START0 = 4'd1,
    ST_10_START0 = 4'd2,
    ST_11_START0 = 4'd3,
    ST_00_START1 = 4'd4,
    ST_01_START1 = 4'd5,
    ST_10_START1 = 4'd6,
    ST_11_START1 = 4'd7,
    ST_00_DONE   = 4'd8,
    ST_01_DONE   = 4'd9,
    ST_10_DONE   = 4'd10,
    ST_11_DONE   = 4'd11
  } state_t;

  localparam state_t RESET_STATE = ST_01_DONE;

  // Action taken on one transition of the decoder.
  typedef enum logic [2:0] {
    ACT_START0  = 3'd0,
    ACT_START1  = 3'd1,
    ACT_RX0     = 3'd2,
    ACT_RX1     = 3'd3,
    ACT_ERROR   = 3'd4,
    ACT_UNREACH = 3'd5
  } action_t;

  localparam int unsigned OUT_COUNT_W = 16;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned POS_W       = 3;

  // One decoded result.
  typedef struct packed {
    logic                   bit_valid;
    logic                   decoded_bit;
    logic [BYTE_W-1:0]      assembled_byte;
    logic                   byte_complete;
    logic                   symbol_error;
    logic [OUT_COUNT_W-1:0] error_count;
    logic [OUT_COUNT_W-1:0] longest_run;
  } result_t;

endpackage

/* hdl/mtd_if.sv */
// ----------------------------------------------------------------------------
// Manchester table decoder channel interfaces
// Valid/ready channels for line samples and for decoded results.
// ----------------------------------------------------------------------------
interface mtd_sample_if;
  logic valid;
  logic ready;
  logic line_level;

  modport source (output valid, output line_level, input ready);
  modport sink (input valid, input line_level, output ready);
endinterface

interface mtd_result_if;
  logic            valid;
  logic            ready;
  mtd_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/mtd_fsm.sv */
// ----------------------------------------------------------------------------
// Manchester table decoder state machine
// Holds the decoder state and gives the action for the current line level.
// ----------------------------------------------------------------------------
module mtd_fsm (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic             line_level,
  output mtd_pkg::action_t action
);

  mtd_pkg::state_t state;
  mtd_pkg::state_t state_next;

  // Next-state table.
  always_comb begin
    case (state)
      mtd_pkg::ST_00_START0: begin
        state_next = line_level ? mtd_pkg::ST_01_DONE : mtd_pkg::ST_00_START0;
      end
      mtd_pkg::ST_01_START0: begin
        state_next = line_level ? mtd_pkg::ST_11_START1 : mtd_pkg::ST_10_START0;
      end
      mtd_pkg::ST_10_START0: begin
        state_next = line_level ? mtd_pkg::ST_01_DONE : mtd_pkg::ST_00_START0;
      end
      mtd_pkg::ST_11_START0: begin
        state_next = line_level ? mtd_pkg::ST_11_START1 : mtd_pkg::ST_10_DONE;
      end
      mtd_pkg::ST_00_START1: begin
        state_next = line_level ? mtd_pkg::ST_01_DONE : mtd_pkg::ST_00_START0;
      end
      mtd_pkg::ST_01_START1: begin
        state_next = line_level ? mtd_pkg::ST_11_START1 : mtd_pkg::ST_10_DONE;
      end
      mtd_pkg::ST_10_START1: begin
        state_next = line_level ? mtd_pkg::ST_01_START1 : mtd_pkg::ST_00_START0;
      end
      mtd_pkg::ST_11_START1: begin
        state_next = line_level ? mtd_pkg::ST_11_START1 : mtd_pkg::ST_10_DONE;
      end
      mtd_pkg::ST_00_DONE: begin
        state_next = line_level ? mtd_pkg::ST_01_DONE : mtd_pkg::ST_00_START0;
      end
      mtd_pkg::ST_01_DONE: begin
        state_next = line_level ? mtd_pkg::ST_11_START1 : mtd_pkg::ST_10_START0;
      end
      mtd_pkg::ST_10_DONE: begin
        state_next = line_level ? mtd_pkg::ST_01_START1 : mtd_pkg::ST_00_START0;
      end
      mtd_pkg::ST_11_DONE: begin
        state_next = line_level ? mtd_pkg::ST_11_START1 : mtd_pkg::ST_10_DONE;
      end
      default: begin
        state_next = mtd_pkg::RESET_STATE;
      end
    endcase
  end

  // Action table.
  always_comb begin
    case (state)
      mtd_pkg::ST_00_START0, mtd_pkg::ST_00_START1, mtd_pkg::ST_00_DONE: begin
        action = line_level ? mtd_pkg::ACT_RX0 : mtd_pkg::ACT_ERROR;
      end
      mtd_pkg::ST_01_START0: begin
        action = mtd_pkg::ACT_UNREACH;
      end
      mtd_pkg::ST_10_START0: begin
        action = line_level ? mtd_pkg::ACT_RX0 : mtd_pkg::ACT_START0;
      end
      mtd_pkg::ST_11_START0, mtd_pkg::ST_11_START1, mtd_pkg::ST_11_DONE: begin
        action = line_level ? mtd_pkg::ACT_ERROR : mtd_pkg::ACT_RX1;
      end
      mtd_pkg::ST_01_START1: begin
        action = line_level ? mtd_pkg::ACT_START1 : mtd_pkg::ACT_RX1;
      end
      mtd_pkg::ST_10_START1: begin
        action = line_level ? mtd_pkg::ACT_UNREACH : mtd_pkg::ACT_START0;
      end
      mtd_pkg::ST_01_DONE, mtd_pkg::ST_10_DONE: begin
        action = line_level ? mtd_pkg::ACT_START1 : mtd_pkg::ACT_START0;
      end
      default: begin
        action = mtd_pkg::ACT_UNREACH;
      end
    endcase
  end

  // State register advances once per processed sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mtd_pkg::RESET_STATE;
    end else if (step) begin
      state <= state_next;
    end
  end

endmodule

/* hdl/mtd_assembler.sv */
// ----------------------------------------------------------------------------
// Manchester table decoder byte assembler and statistics
// Packs decoded bits into a byte and keeps saturating error and run counters.
// ----------------------------------------------------------------------------
module mtd_assembler #(
  parameter int unsigned COUNTER_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step,
  input  mtd_pkg::action_t               action,
  input  logic [mtd_pkg::POS_W-1:0]      bit_phase,
  output mtd_pkg::result_t               result
);

  localparam int unsigned EXT_W = COUNTER_WIDTH + mtd_pkg::OUT_COUNT_W;

  logic [mtd_pkg::BYTE_W-1:0] byte_shift;
  logic [mtd_pkg::BYTE_W-1:0] byte_shift_next;
  logic [mtd_pkg::POS_W-1:0]  bits_received;
  logic [mtd_pkg::POS_W-1:0]  bits_received_next;
  logic [COUNTER_WIDTH-1:0]   errors_seen;
  logic [COUNTER_WIDTH-1:0]   errors_seen_next;
  logic [COUNTER_WIDTH-1:0]   current_run;
  logic [COUNTER_WIDTH-1:0]   current_run_next;
  logic [COUNTER_WIDTH-1:0]   best_run;
  logic [COUNTER_WIDTH-1:0]   best_run_next;

  logic                       is_rx;
  logic                       is_err;
  logic                       rx_bit;
  logic [mtd_pkg::POS_W-1:0]  slot;
  logic [mtd_pkg::POS_W-1:0]  pos;
  logic [EXT_W-1:0]           err_ext;
  logic [EXT_W-1:0]           best_ext;

  // Classify the action.
  always_comb begin
    is_rx  = (action == mtd_pkg::ACT_RX0) || (action == mtd_pkg::ACT_RX1);
    is_err = (action == mtd_pkg::ACT_ERROR) || (action == mtd_pkg::ACT_UNREACH);
    rx_bit = (action == mtd_pkg::ACT_RX1);
  end

  // Bit position in the byte, MSB first, offset by the configured phase.
  assign slot = bits_received + bit_phase;
  assign pos  = ~slot;

  // Next values of the byte and the counters.
  always_comb begin
    byte_shift_next    = byte_shift;
    bits_received_next = bits_received;
    errors_seen_next   = errors_seen;
    current_run_next   = current_run;
    best_run_next      = best_run;
    if (is_rx) begin
      byte_shift_next[pos] = rx_bit;
      bits_received_next   = bits_received + 1'b1;
      current_run_next     = (&current_run) ? current_run : current_run + 1'b1;
      if (current_run_next > best_run) begin
        best_run_next = current_run_next;
      end
    end else if (is_err) begin
      errors_seen_next = (&errors_seen) ? errors_seen : errors_seen + 1'b1;
      current_run_next = '0;
    end
  end

  // Counter outputs are the low bits of the wider or narrower counters.
  assign err_ext  = {{mtd_pkg::OUT_COUNT_W{1'b0}}, errors_seen_next};
  assign best_ext = {{mtd_pkg::OUT_COUNT_W{1'b0}}, best_run_next};

  // Result of this step, as seen after the update.
  always_comb begin
    result.bit_valid      = is_rx;
    result.decoded_bit    = is_rx && rx_bit;
    result.assembled_byte = byte_shift_next;
    result.byte_complete  = is_rx && (pos == '0);
    result.symbol_error   = is_err;
    result.error_count    = err_ext[mtd_pkg::OUT_COUNT_W-1:0];
    result.longest_run    = best_ext[mtd_pkg::OUT_COUNT_W-1:0];
  end

  // State update once per processed sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_shift    <= '0;
      bits_received <= '0;
      errors_seen   <= '0;
      current_run   <= '0;
      best_run      <= '0;
    end else if (step) begin
      byte_shift    <= byte_shift_next;
      bits_received <= bits_received_next;
      errors_seen   <= errors_seen_next;
      current_run   <= current_run_next;
      best_run      <= best_run_next;
    end
  end

endmodule

/* hdl/manchester_table_decoder.sv */
// ----------------------------------------------------------------------------
// Manchester table decoder
// Table-driven Manchester decoder with byte packing and error statistics.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  samples   in         line_level
//  results   out        result_t (bit, byte, flags, counters)
//  cfg       in         bit_phase write, no read-back
//
// One sample per cycle sustained while results are accepted. A sample is
// registered, then one table step and the counter update run between
// that register and the result register.
// Reset is synchronous and returns the decoder to the idle done state.
// A stalled result holds the input register; input stops only when both full.
// ----------------------------------------------------------------------------
`include "manchester_table_decoder_defines.svh"

module manchester_table_decoder #(
  parameter int unsigned COUNTER_WIDTH = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [mtd_pkg::POS_W-1:0]  cfg_wr_data,
  mtd_sample_if.sink                 samples,
  mtd_result_if.source               results
);

  logic                       s1_valid;
  logic                       s1_level;
  logic                       advance;
  logic                       out_valid;
  mtd_pkg::result_t           out_data;
  logic [mtd_pkg::POS_W-1:0]  bit_phase;
  mtd_pkg::action_t           action;
  mtd_pkg::result_t           step_result;

  // A sample moves on when the result register is free or being drained.
  assign advance       = s1_valid && (!out_valid || results.ready);
  assign samples.ready = !s1_valid || advance;
  assign results.valid = out_valid;
  assign results.data  = out_data;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_phase <= '0;
    end else if (cfg_wr_en) begin
      bit_phase <= cfg_wr_data;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (samples.valid && samples.ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      s1_level <= samples.line_level;
    end
  end

  // Decoder state machine.
  mtd_fsm u_fsm (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .line_level (s1_level),
    .action     (action)
  );

  // Byte packing and statistics.
  mtd_assembler #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_asm (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .action    (action),
    .bit_phase (bit_phase),
    .result    (step_result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= step_result;
    end
  end

  // A result is never both a decoded bit and a symbol error.
  `MTD_ASSERT_NOW(a_rx_err_excl, clk, rst, out_valid,
                  !(out_data.bit_valid && out_data.symbol_error))
  // A completed byte always comes with a decoded bit.
  `MTD_ASSERT_NOW(a_done_has_bit, clk, rst, out_valid && out_data.byte_complete,
                  out_data.bit_valid)
  // A held sample is not lost while the result side stalls.
  `MTD_ASSERT_NEXT(a_s1_held, clk, rst, s1_valid && !advance, s1_valid)

endmodule
